@@ hdl/iu2u8_pkg.sv @@
package iu2u8_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned LenW       = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW       = $clog2(MaxBytes);

  localparam logic [2:0] AddrInvertUnits = 3'd0;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
    logic       end_of_text;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
    logic                     final_unit;
  } job_t;

  function automatic enc_t encode_cp(logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7f) begin
      e.bytes[0] = cp[7:0];
      e.len      = 3'd1;
    end else if (cp <= 21'h7ff) begin
      e.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      e.len      = 3'd2;
    end else if (cp <= 21'hffff) begin
      e.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

@@ hdl/iu2u8_front.sv @@
module iu2u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                invert_units,
  input  logic                in_valid,
  input  iu2u8_pkg::in_item_t in_data,
  input  logic                queue_full,
  output logic                push,
  output iu2u8_pkg::job_t     push_data
);

  logic                   high_pending;
  logic                   high_pending_next;
  logic [9:0]             held_high_surrogate;
  logic [9:0]             held_high_surrogate_next;
  logic                   accept;
  logic [15:0]            unit;
  logic                   is_high;
  logic                   is_low;
  logic                   hold_new;
  logic                   has_first;
  logic                   has_second;
  logic [20:0]            first_cp;
  logic [10:0]            plane;
  iu2u8_pkg::enc_t        first_enc;
  iu2u8_pkg::enc_t        second_enc;

  assign accept = in_valid && !queue_full;

  always_comb begin
    unit       = invert_units ? ~in_data.code_unit : in_data.code_unit;
    is_high    = (unit >= 16'hd800) && (unit <= 16'hdbff);
    is_low     = (unit >= 16'hdc00) && (unit <= 16'hdfff);
    hold_new   = is_high && !in_data.final_unit;
    plane      = {1'b0, held_high_surrogate} + 11'h040;

    if (high_pending && is_low) begin
      first_cp = {plane, unit[9:0]};
    end else if (high_pending) begin
      first_cp = {5'b00000, 6'b110110, held_high_surrogate};
    end else begin
      first_cp = {5'b00000, unit};
    end
    first_enc  = iu2u8_pkg::encode_cp(first_cp);
    second_enc = iu2u8_pkg::encode_cp({5'b00000, unit});
    has_first  = high_pending || !hold_new;
    has_second = high_pending && !is_low && !hold_new;

    push_data            = '0;
    push_data.final_unit = in_data.final_unit;
    for (int k = 0; k < 4; k++) begin
      push_data.bytes[k] = first_enc.bytes[k];
    end
    push_data.len = iu2u8_pkg::LenW'(first_enc.len);
    if (has_second) begin
      for (int k = 0; k < 3; k++) begin
        push_data.bytes[3 + k] = second_enc.bytes[k];
      end
      push_data.len = iu2u8_pkg::LenW'(first_enc.len)
                      + iu2u8_pkg::LenW'(second_enc.len);
    end
    push = accept && has_first;

    high_pending_next        = high_pending;
    held_high_surrogate_next = held_high_surrogate;
    if (accept) begin
      if (high_pending && is_low) begin
        high_pending_next = 1'b0;
      end else begin
        high_pending_next = hold_new;
        if (hold_new) begin
          held_high_surrogate_next = unit[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending        <= 1'b0;
      held_high_surrogate <= '0;
    end else begin
      high_pending        <= high_pending_next;
      held_high_surrogate <= held_high_surrogate_next;
    end
  end

endmodule

@@ hdl/iu2u8_queue.sv @@
module iu2u8_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iu2u8_pkg::job_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            nonempty,
  output iu2u8_pkg::job_t head
);

  iu2u8_pkg::job_t                      slots [iu2u8_pkg::QueueDepth];
  logic [iu2u8_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [iu2u8_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [iu2u8_pkg::QueueCntW-1:0]      count;
  logic                                 do_push;
  logic                                 do_pop;

  assign full     = (count == iu2u8_pkg::QueueCntW'(iu2u8_pkg::QueueDepth));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == iu2u8_pkg::QueuePtrW'(iu2u8_pkg::QueueDepth - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == iu2u8_pkg::QueuePtrW'(iu2u8_pkg::QueueDepth - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      count <= count + iu2u8_pkg::QueueCntW'(do_push) - iu2u8_pkg::QueueCntW'(do_pop);
    end
  end

endmodule

@@ hdl/iu2u8_back.sv @@
module iu2u8_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  iu2u8_pkg::job_t      job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iu2u8_pkg::out_item_t out_data
);

  logic [iu2u8_pkg::IdxW-1:0] idx;
  logic [iu2u8_pkg::IdxW-1:0] idx_next;
  logic                       out_valid_next;
  logic                       advance;
  logic                       last_byte;

  always_comb begin
    advance        = !out_valid || !out_stall;
    last_byte      = (iu2u8_pkg::LenW'(idx) + 1'b1) == job.len;
    pop            = advance && job_valid && last_byte;
    idx_next       = idx;
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = job_valid;
      if (job_valid) begin
        idx_next = last_byte ? '0 : idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && job_valid) begin
      out_data.utf8_byte   <= job.bytes[idx];
      out_data.last_of_run <= last_byte;
      out_data.end_of_text <= last_byte && job.final_unit;
    end
  end

endmodule

@@ hdl/inverted_utf16_to_utf8.sv @@
// Bit-inverted UTF-16 to UTF-8 transcoder.
// Input channel (in_valid/in_stall/in_data) takes one stored code unit per
// transfer plus a flag on the last unit of a string. Output channel
// (out_valid/out_stall/out_data) gives one UTF-8 byte per transfer, with
// last_of_run on the final byte of a unit and end_of_text on the final byte
// of a string. A high surrogate that is not final is held and gives no byte
// until the next unit arrives.
// The APB port holds invert_units at address 0 (reset 1); write it only
// while the block is idle.
// A unit's first byte passes through the job queue and then the output register.
// Throughput: one byte per cycle at the output while the receiver does not
// stall; the byte serializer sends a unit's bytes one at a time, so units come
// in at one per cycle while the two-entry job queue has room.
// Reset (synchronous, rst high) empties the queue, drops any held surrogate
// and sets invert_units. When the receiver stalls, the output byte holds,
// the queue fills and in_stall rises once it is full.
module inverted_utf16_to_utf8 (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iu2u8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iu2u8_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic            invert_units;
  logic            push;
  logic            pop;
  logic            full;
  logic            nonempty;
  iu2u8_pkg::job_t push_data;
  iu2u8_pkg::job_t head;

  assign pready   = 1'b1;
  assign in_stall = full;
  assign prdata   = (paddr == iu2u8_pkg::AddrInvertUnits) ? {31'd0, invert_units} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_units <= 1'b1;
    end else if (psel && penable && pwrite && pready
                 && paddr == iu2u8_pkg::AddrInvertUnits) begin
      invert_units <= pwdata[0];
    end
  end

  iu2u8_front u_front (
    .clk          (clk),
    .rst          (rst),
    .invert_units (invert_units),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .queue_full   (full),
    .push         (push),
    .push_data    (push_data)
  );

  iu2u8_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (full),
    .nonempty  (nonempty),
    .head      (head)
  );

  iu2u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (nonempty),
    .job       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/transcode_checker.sv @@
`timescale 1ns / 100ps
module transcode_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  iu2u8_pkg::in_item_t   in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  iu2u8_pkg::out_item_t  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output int                    mismatch_total,
  output int                    bytes_due
);

  iu2u8_pkg::out_item_t utf8_due [$];
  logic        invert_on;
  logic        surrogate_held;
  logic [9:0]  held_bits;
  logic [7:0]  run_bytes [6];
  int unsigned run_len;
  int          fails;

  initial begin
    fails = 0;
    run_len = 0;
    invert_on = 1'b1;
    surrogate_held = 1'b0;
    held_bits = '0;
  end

  task automatic add_byte(input logic [7:0] b);
    run_bytes[run_len] = b;
    run_len++;
  endtask

  task automatic add_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic predict_utf8(input iu2u8_pkg::in_item_t item);
    logic [15:0]          unit;
    logic                 is_high;
    logic                 is_low;
    logic                 paired;
    iu2u8_pkg::out_item_t entry;
    unit = invert_on ? ~item.code_unit : item.code_unit;
    is_high = unit[15:10] == 6'b110110;
    is_low = unit[15:10] == 6'b110111;
    paired = 1'b0;
    run_len = 0;
    if (surrogate_held) begin
      surrogate_held = 1'b0;
      if (is_low) begin
        paired = 1'b1;
        add_code_point(21'h10000 + 21'({held_bits, unit[9:0]}));
      end else begin
        add_code_point({5'b0, 6'b110110, held_bits});
      end
    end
    if (!paired) begin
      if (is_high && !item.final_unit) begin
        held_bits = unit[9:0];
        surrogate_held = 1'b1;
      end else begin
        add_code_point({5'b0, unit});
      end
    end
    for (int i = 0; i < run_len; i++) begin
      entry.utf8_byte = run_bytes[i];
      entry.last_of_run = (i == run_len - 1);
      entry.end_of_text = (i == run_len - 1) && item.final_unit;
      utf8_due = {utf8_due, entry};
    end
  endtask

  task automatic check_byte(input iu2u8_pkg::out_item_t got);
    iu2u8_pkg::out_item_t want;
    if (utf8_due.size() == 0) begin
      fails++;
      $display("%0t: unexpected transfer, expected none, actual %h", $time, got);
    end else begin
      want = utf8_due.pop_front();
      if (got.utf8_byte !== want.utf8_byte) begin
        fails++;
        $display("%0t: utf8_byte expected %h, actual %h", $time, want.utf8_byte,
                 got.utf8_byte);
      end
      if (got.last_of_run !== want.last_of_run) begin
        fails++;
        $display("%0t: last_of_run expected %b, actual %b", $time, want.last_of_run,
                 got.last_of_run);
      end
      if (got.end_of_text !== want.end_of_text) begin
        fails++;
        $display("%0t: end_of_text expected %b, actual %b", $time, want.end_of_text,
                 got.end_of_text);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      invert_on = 1'b1;
      surrogate_held = 1'b0;
      held_bits = '0;
      utf8_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == iu2u8_pkg::AddrInvertUnits) begin
        invert_on = pwdata[0];
      end
      if (in_valid && !in_stall) begin
        predict_utf8(in_data);
      end
      if (out_valid && !out_stall) begin
        check_byte(out_data);
      end
    end
    mismatch_total <= fails;
    bytes_due <= utf8_due.size();
  end

endmodule

@@ test/tb_inverted_utf16_to_utf8.sv @@
`timescale 1ns / 100ps
module tb_inverted_utf16_to_utf8;

  localparam int unsigned CycleLimit = 200000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  iu2u8_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  iu2u8_pkg::out_item_t out_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [2:0]           paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int          mismatch_total;
  int          bytes_due;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 18;
  int unsigned stall_pct = 80;
  int unsigned hold_requests = 0;
  int unsigned units_sent = 0;
  logic        invert_setting = 1'b1;

  inverted_utf16_to_utf8 i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  transcode_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatch_total(mismatch_total),
    .bytes_due     (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off on request
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_coded(input logic [15:0] unit, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{code_unit: (invert_setting ? ~unit : unit), final_unit: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    units_sent++;
  endtask

  task automatic wait_drained(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_invert(input logic inv);
    write_reg(iu2u8_pkg::AddrInvertUnits, {31'b0, inv});
    invert_setting = inv;
  endtask

  // mostly well-formed strings; lone surrogates and raw units as noise
  task automatic send_random_string();
    int unsigned len;
    int unsigned k;
    logic [15:0] u;
    len = $urandom_range(1, 6);
    k = 0;
    while (k < len) begin
      case ($urandom_range(0, 9))
        0, 1: u = 16'($urandom_range(16'h0000, 16'h007f));
        2: u = 16'($urandom_range(16'h0080, 16'h07ff));
        3: u = 16'($urandom_range(16'h0800, 16'hd7ff));
        4: u = 16'($urandom_range(16'he000, 16'hffff));
        5, 6: begin
          send_coded(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0);
          k++;
          u = 16'($urandom_range(16'hdc00, 16'hdfff));
        end
        7: u = 16'($urandom_range(16'hd800, 16'hdbff));
        8: u = 16'($urandom_range(16'hdc00, 16'hdfff));
        default: u = 16'($urandom);
      endcase
      send_coded(u, k + 1 >= len);
      k++;
    end
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input logic inv, input int unsigned count,
                           input bit pause_mid, input bit hold_mid);
    int unsigned first_unit;
    wait_drained(8);
    set_invert(inv);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    first_unit = units_sent;
    while (units_sent - first_unit < count) begin
      send_random_string();
      if (pause_mid && units_sent - first_unit >= count / 2) begin
        pause_mid = 1'b0;
        wait_drained(0);
      end
      if (hold_mid && units_sent - first_unit >= count / 3) begin
        hold_mid = 1'b0;
        hold_requests++;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_invert(1'b0);
    send_coded(16'h0000, 1'b0);
    send_coded(16'h007f, 1'b0);
    send_coded(16'h0080, 1'b0);
    send_coded(16'h07ff, 1'b0);
    send_coded(16'h0800, 1'b0);
    send_coded(16'hffff, 1'b1);
    send_coded(16'hd800, 1'b0);
    send_coded(16'hdc00, 1'b0);
    send_coded(16'hdbff, 1'b0);
    send_coded(16'hdfff, 1'b1);
    send_coded(16'hdc00, 1'b0);
    send_coded(16'hdfff, 1'b0);
    send_coded(16'hd912, 1'b0);
    send_coded(16'h0041, 1'b0);
    send_coded(16'hd801, 1'b0);
    send_coded(16'hdb00, 1'b0);
    send_coded(16'hdc05, 1'b0);
    send_coded(16'hdabc, 1'b1);
    send_coded(16'hd800, 1'b0);
    send_coded(16'h0000, 1'b1);
    // hold a high surrogate across a setting change
    send_coded(16'hd834, 1'b0);
    wait_drained(8);
    set_invert(1'b1);
    send_coded(16'hdd1e, 1'b1);
    send_coded(16'h0000, 1'b0);
    send_coded(16'hffff, 1'b1);
    send_coded(16'hd83d, 1'b0);
    send_coded(16'hde00, 1'b1);

    run_phase(18, 80, 1'b1, 65, 1'b0, 1'b0);
    run_phase(80, 18, 1'b0, 65, 1'b1, 1'b0);
    run_phase(0, 0, 1'b1, 60, 1'b0, 1'b1);

    wait_drained(20);
    if (mismatch_total == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
